### rtl/core/dalp_pkg.sv
// Shared types and constants for the destination-address list parser.
// No dependencies; used by the top level dest_address_list_parser.
package dalp_pkg;

    // Function codes carried with each input word.
    localparam logic [1:0] FUNC_DATA    = 2'd0;
    localparam logic [1:0] FUNC_END     = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_END   = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Entry kinds.
    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_LIST    = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ADDRESS_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_LIST_NAME_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ADDRESS_FLAG    = 2'd2;
    localparam logic [1:0] CFG_LIST_FLAG       = 2'd3;

    // Configuration reset values.
    localparam logic [7:0] RST_ADDRESS_LIMIT   = 8'd21;
    localparam logic [7:0] RST_LIST_NAME_LIMIT = 8'd21;
    localparam logic [7:0] RST_ADDRESS_FLAG    = 8'd1;
    localparam logic [7:0] RST_LIST_FLAG       = 8'd2;

    // String terminator and offset saturation point.
    localparam logic [7:0]  NUL_BYTE   = 8'h00;
    localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

    // One result word.
    typedef struct packed {
        logic [1:0]  status;
        logic        entry_kind;
        logic [7:0]  type_of_number;
        logic [7:0]  numbering_plan;
        logic [15:0] string_offset;
        logic [7:0]  string_length;
        logic [15:0] consumed_length;
    } result_t;

endpackage

### rtl/core/dest_address_list_parser.sv
// Destination-address list parser: byte-wide list walker with a two-word output buffer.
// Depends on dalp_pkg for codes, configuration reset values and the result type.

// The parser takes one list byte (or an end or restart word) in every clock cycle and
// registers the result for that word, if any, in the output word or, if that waits, the skid word. The rate is set by
// the single per-byte state update; a result word and a skid word sit between the parser
// and the output, so input is stalled only while both are full. Configuration writes are
// always ready and take effect at the next word; write them only while the parser is idle.
module dest_address_list_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  byte_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        entry_kind,
    output logic [7:0]  type_of_number,
    output logic [7:0]  numbering_plan,
    output logic [15:0] string_offset,
    output logic [7:0]  string_length,
    output logic [15:0] consumed_length,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_TON,
        PH_NPI,
        PH_ADDR,
        PH_NAME
    } phase_t;

    // Configuration registers.
    logic [7:0] address_limit_reg;
    logic [7:0] list_name_limit_reg;
    logic [7:0] address_flag_reg;
    logic [7:0] list_flag_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic        halted_reg, halted_next;
    logic        kind_reg, kind_next;
    logic [7:0]  ton_reg, ton_next;
    logic [7:0]  npi_reg, npi_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [15:0] string_start_reg, string_start_next;
    logic [15:0] entry_start_reg, entry_start_next;

    // Output buffer.
    logic               out_valid_reg;
    logic               skid_valid_reg;
    dalp_pkg::result_t  out_reg;
    dalp_pkg::result_t  skid_reg;

    logic               in_fire;
    logic               out_fire;
    logic               push;
    dalp_pkg::result_t  res;
    logic [15:0]        offset_inc;
    logic [7:0]         limit;
    logic [7:0]         count_inc;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign entry_kind      = out_reg.entry_kind;
    assign type_of_number  = out_reg.type_of_number;
    assign numbering_plan  = out_reg.numbering_plan;
    assign string_offset   = out_reg.string_offset;
    assign string_length   = out_reg.string_length;
    assign consumed_length = out_reg.consumed_length;

    // Saturating next byte offset and the limit of the string being searched.
    assign offset_inc = (byte_offset_reg == dalp_pkg::OFFSET_MAX) ? byte_offset_reg
                                                                   : byte_offset_reg + 16'd1;
    assign limit      = (phase_reg == PH_ADDR) ? address_limit_reg : list_name_limit_reg;
    assign count_inc  = count_reg + 8'd1;

    // Per-word parse step.
    always_comb
    begin
        phase_next        = phase_reg;
        halted_next       = halted_reg;
        kind_next         = kind_reg;
        ton_next          = ton_reg;
        npi_next          = npi_reg;
        count_next        = count_reg;
        byte_offset_next  = byte_offset_reg;
        string_start_next = string_start_reg;
        entry_start_next  = entry_start_reg;
        push              = 1'b0;
        res               = '0;
        res.status        = dalp_pkg::STATUS_BAD;
        res.consumed_length = entry_start_reg;

        if (func == dalp_pkg::FUNC_RESTART)
        begin
            phase_next        = PH_FLAG;
            halted_next       = 1'b0;
            kind_next         = dalp_pkg::KIND_ADDRESS;
            ton_next          = '0;
            npi_next          = '0;
            count_next        = '0;
            byte_offset_next  = '0;
            string_start_next = '0;
            entry_start_next  = '0;
        end
        else if (halted_reg)
        begin
            // Silent until restart.
        end
        else if (func == dalp_pkg::FUNC_END)
        begin
            push        = 1'b1;
            halted_next = 1'b1;
            res.status  = (phase_reg == PH_FLAG) ? dalp_pkg::STATUS_END
                                                 : dalp_pkg::STATUS_BAD;
        end
        else if (func == dalp_pkg::FUNC_DATA)
        begin
            case (phase_reg)
                PH_FLAG:
                begin
                    byte_offset_next = offset_inc;
                    if (byte_value == address_flag_reg)
                    begin
                        kind_next  = dalp_pkg::KIND_ADDRESS;
                        phase_next = PH_TON;
                    end
                    else if (byte_value == list_flag_reg)
                    begin
                        kind_next         = dalp_pkg::KIND_LIST;
                        ton_next          = '0;
                        npi_next          = '0;
                        count_next        = '0;
                        string_start_next = offset_inc;
                        phase_next        = PH_NAME;
                    end
                    else
                    begin
                        push        = 1'b1;
                        halted_next = 1'b1;
                    end
                end
                PH_TON:
                begin
                    byte_offset_next = offset_inc;
                    ton_next         = byte_value;
                    phase_next       = PH_NPI;
                end
                PH_NPI:
                begin
                    byte_offset_next  = offset_inc;
                    npi_next          = byte_value;
                    count_next        = '0;
                    string_start_next = offset_inc;
                    phase_next        = PH_ADDR;
                end
                PH_ADDR, PH_NAME:
                begin
                    if (count_reg >= limit)
                    begin
                        // Limit was already used up, e.g. a zero limit.
                        push        = 1'b1;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        byte_offset_next = offset_inc;
                        if (byte_value == dalp_pkg::NUL_BYTE)
                        begin
                            push                = 1'b1;
                            res.status          = dalp_pkg::STATUS_OK;
                            res.entry_kind      = kind_reg;
                            res.type_of_number  = ton_reg;
                            res.numbering_plan  = npi_reg;
                            res.string_offset   = string_start_reg;
                            res.string_length   = count_reg;
                            res.consumed_length = offset_inc;
                            entry_start_next    = offset_inc;
                            phase_next          = PH_FLAG;
                        end
                        else
                        begin
                            count_next = count_inc;
                            if (count_inc >= limit)
                            begin
                                push        = 1'b1;
                                halted_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_FLAG;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_limit_reg   <= dalp_pkg::RST_ADDRESS_LIMIT;
            list_name_limit_reg <= dalp_pkg::RST_LIST_NAME_LIMIT;
            address_flag_reg    <= dalp_pkg::RST_ADDRESS_FLAG;
            list_flag_reg       <= dalp_pkg::RST_LIST_FLAG;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dalp_pkg::CFG_ADDRESS_LIMIT:   address_limit_reg   <= cfg_data;
                dalp_pkg::CFG_LIST_NAME_LIMIT: list_name_limit_reg <= cfg_data;
                dalp_pkg::CFG_ADDRESS_FLAG:    address_flag_reg    <= cfg_data;
                dalp_pkg::CFG_LIST_FLAG:       list_flag_reg       <= cfg_data;
                default:                       list_flag_reg       <= list_flag_reg;
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FLAG;
            halted_reg       <= 1'b0;
            kind_reg         <= dalp_pkg::KIND_ADDRESS;
            ton_reg          <= '0;
            npi_reg          <= '0;
            count_reg        <= '0;
            byte_offset_reg  <= '0;
            string_start_reg <= '0;
            entry_start_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            halted_reg       <= halted_next;
            kind_reg         <= kind_next;
            ton_reg          <= ton_next;
            npi_reg          <= npi_next;
            count_reg        <= count_next;
            byte_offset_reg  <= byte_offset_next;
            string_start_reg <= string_start_next;
            entry_start_reg  <= entry_start_next;
        end
    end

    // Output word and skid word valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && push)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output and skid payload.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire && push)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    // The skid word is only ever filled behind a waiting output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    // A restart returns the parser to the start of a fresh list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func == dalp_pkg::FUNC_RESTART) |=>
            (phase_reg == PH_FLAG && !halted_reg && byte_offset_reg == 16'd0))
        else $error("restart did not clear the parser");

    // While halted, data words leave the offset untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && halted_reg && func == dalp_pkg::FUNC_DATA) |=>
            $stable(byte_offset_reg) && halted_reg)
        else $error("halted parser moved on a data word");

    // An end or malformed result always halts the parser.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && push && res.status != dalp_pkg::STATUS_OK) |=> halted_reg)
        else $error("end or malformed result without halt");

    // A parsed entry moves the consumed length to the current offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && push && res.status == dalp_pkg::STATUS_OK) |=>
            (entry_start_reg == byte_offset_reg && phase_reg == PH_FLAG))
        else $error("entry boundary not recorded");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the destination-address list parser.
// Depends on dalp_pkg and dest_address_list_parser; stimulus and expected results
// are generated here, with an in-bench model of the list walker.
module tb_top;

    localparam logic [1:0] FUNC_IGNORED = 2'd3;
    localparam int IDLE_PERCENT  = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 780;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int LONG_ENTRIES  = 2;

    typedef enum logic [2:0] {AT_FLAG, AT_TON, AT_NPI, AT_ADDRESS, AT_NAME} parse_step_t;
    typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_STOP} row_check_t;

    typedef struct {
        logic [1:0]  f;
        logic [7:0]  b;
        row_check_t  check;
        logic [1:0]  want_status;
        logic [15:0] want_consumed;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [7:0]  byte_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        entry_kind;
    logic [7:0]  type_of_number;
    logic [7:0]  numbering_plan;
    logic [15:0] string_offset;
    logic [7:0]  string_length;
    logic [15:0] consumed_length;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Model copy of the registers.
    logic [7:0]  lim_address;
    logic [7:0]  lim_name;
    logic [7:0]  flag_address;
    logic [7:0]  flag_list;

    // Model copy of the walker state.
    parse_step_t step_now;
    bit          list_halted;
    logic        kind_now;
    logic [7:0]  ton_now;
    logic [7:0]  npi_now;
    logic [7:0]  str_count;
    logic [15:0] next_offset;
    logic [15:0] str_start;
    logic [15:0] entry_start;

    dalp_pkg::result_t pending_results[$];
    stim_row_t         directed_rows[$];
    int        errors = 0;
    int        words_taken = 0;
    int        results_checked = 0;
    int        settings_used = 0;
    int        idle_cycles = 0;
    bit        calm;

    dest_address_list_parser DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .byte_value      (byte_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_kind      (entry_kind),
        .type_of_number  (type_of_number),
        .numbering_plan  (numbering_plan),
        .string_offset   (string_offset),
        .string_length   (string_length),
        .consumed_length (consumed_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Walker model
    // ------------------------------------------------------------------

    function automatic void clear_parse();
        step_now    = AT_FLAG;
        list_halted = 1'b0;
        kind_now    = dalp_pkg::KIND_ADDRESS;
        ton_now     = '0;
        npi_now     = '0;
        str_count   = '0;
        next_offset = '0;
        str_start   = '0;
        entry_start = '0;
    endfunction

    // The offset of the next list byte sticks at its maximum.
    function automatic void bump_offset();
        if (next_offset != dalp_pkg::OFFSET_MAX)
            next_offset = next_offset + 16'd1;
    endfunction

    function automatic void open_string();
        str_count = '0;
        str_start = next_offset;
    endfunction

    // End and malformed words carry only the length through the last good entry.
    function automatic bit stop_parse(input logic [1:0] code, output dalp_pkg::result_t r);
        r = '0;
        r.status = code;
        r.consumed_length = entry_start;
        list_halted = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit predict_step(input logic [1:0] f, input logic [7:0] b,
                                        output dalp_pkg::result_t r);
        logic [7:0] lim;
        r = '0;
        if (f == dalp_pkg::FUNC_RESTART)
        begin
            clear_parse();
            return 1'b0;
        end
        if (f == FUNC_IGNORED || list_halted)
            return 1'b0;
        if (f == dalp_pkg::FUNC_END)
            return stop_parse((step_now == AT_FLAG) ? dalp_pkg::STATUS_END
                                                    : dalp_pkg::STATUS_BAD, r);
        case (step_now)
            AT_FLAG:
            begin
                bump_offset();
                // The address code wins when both flag codes are equal.
                if (b == flag_address)
                begin
                    kind_now = dalp_pkg::KIND_ADDRESS;
                    step_now = AT_TON;
                end
                else if (b == flag_list)
                begin
                    kind_now = dalp_pkg::KIND_LIST;
                    ton_now  = '0;
                    npi_now  = '0;
                    open_string();
                    step_now = AT_NAME;
                end
                else
                    return stop_parse(dalp_pkg::STATUS_BAD, r);
            end
            AT_TON:
            begin
                bump_offset();
                ton_now  = b;
                step_now = AT_NPI;
            end
            AT_NPI:
            begin
                bump_offset();
                npi_now = b;
                open_string();
                step_now = AT_ADDRESS;
            end
            default:
            begin
                lim = (step_now == AT_ADDRESS) ? lim_address : lim_name;
                if (str_count >= lim)
                    return stop_parse(dalp_pkg::STATUS_BAD, r);
                bump_offset();
                if (b == dalp_pkg::NUL_BYTE)
                begin
                    r.status          = dalp_pkg::STATUS_OK;
                    r.entry_kind      = kind_now;
                    r.type_of_number  = ton_now;
                    r.numbering_plan  = npi_now;
                    r.string_offset   = str_start;
                    r.string_length   = str_count;
                    r.consumed_length = next_offset;
                    entry_start = next_offset;
                    step_now    = AT_FLAG;
                    return 1'b1;
                end
                str_count = str_count + 8'd1;
                // The byte that fills the limit without a terminator is malformed.
                if (str_count >= lim)
                    return stop_parse(dalp_pkg::STATUS_BAD, r);
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_error(input string text);
        $display("ERROR at %0t: %s", $time, text);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Compare each accepted result word against the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        dalp_pkg::result_t seen;
        dalp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {status, entry_kind, type_of_number, numbering_plan,
                    string_offset, string_length, consumed_length};
            if (pending_results.size() == 0)
                flag_error($sformatf("result word with nothing pending: status %0d",
                                     status));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("status", 16'(seen.status), 16'(want.status));
                check_field("entry_kind", 16'(seen.entry_kind), 16'(want.entry_kind));
                check_field("type_of_number", 16'(seen.type_of_number),
                            16'(want.type_of_number));
                check_field("numbering_plan", 16'(seen.numbering_plan),
                            16'(want.numbering_plan));
                check_field("string_offset", seen.string_offset, want.string_offset);
                check_field("string_length", 16'(seen.string_length),
                            16'(want.string_length));
                check_field("consumed_length", seen.consumed_length,
                            want.consumed_length);
            end
        end
    end

    // Result side stalls at random, except during the calm stretch.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

    // Watchdog: too many cycles without any handshake ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Drive one word, wait for it to be taken, and record what it should produce.
    task automatic push_word(input logic [1:0] f, input logic [7:0] b,
                             input row_check_t check = ROW_PREDICT,
                             input logic [1:0] want_status = dalp_pkg::STATUS_OK,
                             input logic [15:0] want_consumed = 16'd0);
        dalp_pkg::result_t predicted;
        dalp_pkg::result_t typed;
        bit                has_result;
        if (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        byte_value <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (f == dalp_pkg::FUNC_RESTART || (f != FUNC_IGNORED && !list_halted))
            words_taken++;
        has_result = predict_step(f, b, predicted);
        typed = '0;
        typed.status = want_status;
        typed.consumed_length = want_consumed;
        case (check)
            ROW_PREDICT: if (has_result) pending_results.push_back(predicted);
            ROW_STOP:    pending_results.push_back(typed);
            default:     ;
        endcase
    endtask

    // Wait until every expected result is out, with the input side idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            dalp_pkg::CFG_ADDRESS_LIMIT:   lim_address  = data;
            dalp_pkg::CFG_LIST_NAME_LIMIT: lim_name     = data;
            dalp_pkg::CFG_ADDRESS_FLAG:    flag_address = data;
            default:                       flag_list    = data;
        endcase
    endtask

    task automatic configure(input logic [7:0] al, input logic [7:0] ll,
                             input logic [7:0] af, input logic [7:0] lf);
        write_reg(dalp_pkg::CFG_ADDRESS_LIMIT, al);
        write_reg(dalp_pkg::CFG_LIST_NAME_LIMIT, ll);
        write_reg(dalp_pkg::CFG_ADDRESS_FLAG, af);
        write_reg(dalp_pkg::CFG_LIST_FLAG, lf);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic add_row(input logic [1:0] f, input logic [7:0] b,
                           input row_check_t check = ROW_PREDICT,
                           input logic [1:0] want_status = dalp_pkg::STATUS_OK,
                           input logic [15:0] want_consumed = 16'd0);
        stim_row_t row;
        row.f = f;
        row.b = b;
        row.check = check;
        row.want_status = want_status;
        row.want_consumed = want_consumed;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Random list generation
    // ------------------------------------------------------------------

    // A data word, now and then preceded by an ignored function code.
    task automatic push_data(input logic [7:0] b);
        if ($urandom_range(39) == 0)
            push_word(FUNC_IGNORED, 8'($urandom_range(255)));
        push_word(dalp_pkg::FUNC_DATA, b);
    endtask

    task automatic send_string(input int len);
        repeat (len) push_data(8'($urandom_range(255, 1)));
    endtask

    // Mostly short strings, sometimes the longest one that fits.
    function automatic int pick_length(input int lim);
        int top;
        top = lim - 1;
        if ($urandom_range(15) == 0)
            return top;
        if (top > 10 && $urandom_range(7) != 0)
            top = 10;
        return $urandom_range(top, 0);
    endfunction

    task automatic send_entry(input bit overlong);
        bit as_list;
        int lim;
        as_list = (flag_list != flag_address) && ($urandom_range(1) == 1);
        if (as_list)
        begin
            push_data(flag_list);
            lim = int'(lim_name);
        end
        else
        begin
            push_data(flag_address);
            push_data(8'($urandom_range(255)));
            push_data(8'($urandom_range(255)));
            lim = int'(lim_address);
        end
        if (overlong)
            send_string(lim);
        else
        begin
            send_string(pick_length(lim));
            push_data(dalp_pkg::NUL_BYTE);
        end
    endtask

    // One list: restart, a few good entries, then a clean end or some fault.
    task automatic send_list();
        int         ending;
        logic [7:0] odd_flag;
        logic [1:0] f_noise;
        push_word(dalp_pkg::FUNC_RESTART, 8'($urandom_range(255)));
        repeat ($urandom_range(4))
        begin
            if ($urandom_range(19) == 0)
                push_word(dalp_pkg::FUNC_RESTART, 8'($urandom_range(255)));
            send_entry(1'b0);
        end
        ending = $urandom_range(9);
        case (ending)
            0:
            begin
                do
                    odd_flag = 8'($urandom_range(255));
                while (odd_flag == flag_address || odd_flag == flag_list);
                push_data(odd_flag);
            end
            1: send_entry(1'b1);
            2:
            begin
                // Region end in the middle of an address entry.
                push_data(flag_address);
                if ($urandom_range(1) == 1)
                begin
                    push_data(8'($urandom_range(255)));
                    push_data(8'($urandom_range(255)));
                    send_string(pick_length(int'(lim_address)));
                end
                push_word(dalp_pkg::FUNC_END, 8'($urandom_range(255)));
            end
            3:
            begin
                repeat ($urandom_range(8, 1))
                    push_word(2'($urandom_range(3)), 8'($urandom_range(255)));
                push_word(dalp_pkg::FUNC_END, 8'($urandom_range(255)));
            end
            default: push_word(dalp_pkg::FUNC_END, 8'($urandom_range(255)));
        endcase
        // Words after the parser has gone silent.
        repeat ($urandom_range(2))
        begin
            f_noise = 2'($urandom_range(2));
            if (f_noise == dalp_pkg::FUNC_RESTART)
                f_noise = FUNC_IGNORED;
            push_word(f_noise, 8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        logic [7:0] al;
        logic [7:0] ll;
        logic [7:0] af;
        logic [7:0] lf;
        int         phase_goal;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = dalp_pkg::FUNC_DATA;
        byte_value = 8'd0;
        cfg_valid  = 1'b0;
        cfg_index  = dalp_pkg::CFG_ADDRESS_LIMIT;
        cfg_data   = 8'd0;
        calm       = 1'b0;
        lim_address  = dalp_pkg::RST_ADDRESS_LIMIT;
        lim_name     = dalp_pkg::RST_LIST_NAME_LIMIT;
        flag_address = dalp_pkg::RST_ADDRESS_FLAG;
        flag_list    = dalp_pkg::RST_LIST_FLAG;
        clear_parse();

        // Directed words under the reset register values.
        add_row(dalp_pkg::FUNC_END, 8'h00, ROW_STOP, dalp_pkg::STATUS_END, 16'd0);
        add_row(dalp_pkg::FUNC_DATA, 8'hFF, ROW_SILENT);
        add_row(dalp_pkg::FUNC_END, 8'h00, ROW_SILENT);
        add_row(dalp_pkg::FUNC_RESTART, 8'hFF, ROW_SILENT);
        add_row(FUNC_IGNORED, 8'h00, ROW_SILENT);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::RST_ADDRESS_FLAG);
        add_row(dalp_pkg::FUNC_DATA, 8'h00);
        add_row(dalp_pkg::FUNC_DATA, 8'hFF);
        add_row(dalp_pkg::FUNC_DATA, 8'h80);
        add_row(dalp_pkg::FUNC_DATA, 8'h7F);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::NUL_BYTE);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::RST_LIST_FLAG);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::NUL_BYTE);
        add_row(dalp_pkg::FUNC_DATA, 8'h03, ROW_STOP, dalp_pkg::STATUS_BAD, 16'd8);
        add_row(dalp_pkg::FUNC_RESTART, 8'h00, ROW_SILENT);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::RST_LIST_FLAG);
        add_row(dalp_pkg::FUNC_DATA, 8'h41);
        add_row(dalp_pkg::FUNC_END, 8'h55, ROW_STOP, dalp_pkg::STATUS_BAD, 16'd0);
        add_row(dalp_pkg::FUNC_RESTART, 8'hAA, ROW_SILENT);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::RST_ADDRESS_FLAG);
        add_row(dalp_pkg::FUNC_DATA, 8'h12);
        add_row(dalp_pkg::FUNC_DATA, 8'h34);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::NUL_BYTE);
        add_row(dalp_pkg::FUNC_END, 8'h00, ROW_STOP, dalp_pkg::STATUS_END, 16'd4);
        add_row(dalp_pkg::FUNC_DATA, dalp_pkg::RST_ADDRESS_FLAG, ROW_SILENT);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_word(directed_rows[i].f, directed_rows[i].b, directed_rows[i].check,
                      directed_rows[i].want_status, directed_rows[i].want_consumed);
        settle();

        // Random lists over several register settings, extremes first.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: configure(8'd1, 8'd1, 8'h00, 8'h00);
                1: configure(8'd255, 8'd255, 8'hFF, 8'hFE);
                default:
                begin
                    al = 8'($urandom_range(24, 1));
                    ll = 8'($urandom_range(24, 1));
                    af = 8'($urandom_range(255));
                    do
                        lf = 8'($urandom_range(255));
                    while (lf == af);
                    // Last setting makes both flag codes equal.
                    if (p == PHASES - 1)
                        lf = af;
                    configure(al, ll, af, lf);
                end
            endcase
            phase_goal = words_taken + RANDOM_WORDS / PHASES;
            while (words_taken < phase_goal)
            begin
                send_list();
                if ($urandom_range(9) == 0)
                    settle();
            end
            settle();
        end

        // A few names of the longest length at the largest limit.
        // The first half runs with no idling on either side.
        configure(8'd255, 8'd255, dalp_pkg::RST_ADDRESS_FLAG, dalp_pkg::RST_LIST_FLAG);
        calm <= 1'b1;
        push_word(dalp_pkg::FUNC_RESTART, 8'h00);
        for (int n = 0; n < LONG_ENTRIES; n++)
        begin
            if (n == LONG_ENTRIES / 2)
                calm <= 1'b0;
            push_word(dalp_pkg::FUNC_DATA, dalp_pkg::RST_LIST_FLAG);
            repeat (254) push_word(dalp_pkg::FUNC_DATA, 8'($urandom_range(255, 1)));
            push_word(dalp_pkg::FUNC_DATA, dalp_pkg::NUL_BYTE);
        end
        push_word(dalp_pkg::FUNC_DATA, dalp_pkg::RST_ADDRESS_FLAG);
        push_word(dalp_pkg::FUNC_DATA, 8'($urandom_range(255)));
        push_word(dalp_pkg::FUNC_DATA, 8'($urandom_range(255)));
        send_string(3);
        push_word(dalp_pkg::FUNC_DATA, dalp_pkg::NUL_BYTE);
        push_word(dalp_pkg::FUNC_END, 8'h00);

        // A restart must bring the offsets back to zero.
        push_word(dalp_pkg::FUNC_RESTART, 8'h00);
        send_entry(1'b0);
        push_word(dalp_pkg::FUNC_END, 8'h00);

        settle();
        repeat (10) @(posedge clk);
        $display("Run covered %0d list words and %0d result words over %0d register settings,",
                 words_taken, results_checked, settings_used);
        $display("including faults, silent words after a stop, and names of the longest length.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/dalp_pkg.sv
rtl/core/dest_address_list_parser.sv
tb/tb_top.sv
